FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_OUT_W = 6;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_HEAD_ONE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEAD_TWO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAIL_ONE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAIL_TWO = 2'd3;

  localparam logic [BYTE_W-1:0] HEAD_ONE_RST = 8'd170;
  localparam logic [BYTE_W-1:0] HEAD_TWO_RST = 8'd85;
  localparam logic [BYTE_W-1:0] TAIL_ONE_RST = 8'd13;
  localparam logic [BYTE_W-1:0] TAIL_TWO_RST = 8'd10;

  typedef struct packed {
    logic len_load;
    logic sum_clr;
    logic data_wr;
    logic rd_clr;
    logic rd_en;
    logic rd_inc;
    logic out_load;
  } sfr_cmd_t;

  typedef struct packed {
    logic head1_hit;
    logic head2_hit;
    logic tail1_hit;
    logic tail2_hit;
    logic sum_hit;
    logic len_big;
    logic len_zero;
    logic data_done;
    logic out_last;
  } sfr_sts_t;

endpackage

FILE: rtl/core/serial_frame_receiver.sv
// first result: valid after the store read and output load states that follow the second tail byte
// throughput: one byte per cycle while parsing; each result passes through a store read,
// an output load and a handshake, and no byte is taken until the frame drains
// reset: header and tail bytes return to 170, 85, 13, 10 and the parser hunts for
// the first header byte; the payload store is not cleared
`timescale 1ns / 1ps

module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic [LEN_OUT_W-1:0] frame_len_o,
  output logic                 empty_res_o,
  output logic                 last_o
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .payload_byte_o (payload_byte_o),
    .frame_len_o    (frame_len_o),
    .empty_res_o    (empty_res_o),
    .last_o         (last_o)
  );

  // no byte taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // empty frame gives a single zero result
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (last_o && payload_byte_o == '0 && frame_len_o == '0))
    else $error("malformed empty result");

  // last item of a frame returns to the header hunt
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("parser not back in hunt after last item");

  // next item of a frame needs a fresh store read
  a_next_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (!out_valid_o && !in_ready_o))
    else $error("frame emission sequencing broken");

endmodule

FILE: rtl/core/sfr_ctrl.sv
`timescale 1ns / 1ps

module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sfr_sts_t sts_i,
  output sfr_cmd_t cmd_o
);

  localparam logic [3:0] ST_HEAD1   = 4'd0;
  localparam logic [3:0] ST_HEAD2   = 4'd1;
  localparam logic [3:0] ST_LEN     = 4'd2;
  localparam logic [3:0] ST_DATA    = 4'd3;
  localparam logic [3:0] ST_CHECK   = 4'd4;
  localparam logic [3:0] ST_TAIL1   = 4'd5;
  localparam logic [3:0] ST_TAIL2   = 4'd6;
  localparam logic [3:0] ST_EMIT_RD = 4'd7;
  localparam logic [3:0] ST_EMIT_LD = 4'd8;
  localparam logic [3:0] ST_EMIT_WT = 4'd9;

  logic [3:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = state_q inside {[ST_HEAD1:ST_TAIL2]};
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_HEAD1: begin
        if (in_fire && sts_i.head1_hit) state_d = ST_HEAD2;
      end
      ST_HEAD2: begin
        if (in_fire) begin
          if (sts_i.head2_hit) begin
            state_d       = ST_LEN;
            cmd_o.sum_clr = 1'b1;
          end else begin
            state_d = ST_HEAD1;
          end
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          cmd_o.len_load = 1'b1;
          if (sts_i.len_big) state_d = ST_HEAD1;
          else if (sts_i.len_zero) state_d = ST_CHECK;
          else state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd_o.data_wr = 1'b1;
          if (sts_i.data_done) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_fire) state_d = sts_i.sum_hit ? ST_TAIL1 : ST_HEAD1;
      end
      ST_TAIL1: begin
        if (in_fire) state_d = sts_i.tail1_hit ? ST_TAIL2 : ST_HEAD1;
      end
      ST_TAIL2: begin
        if (in_fire) begin
          if (sts_i.tail2_hit) begin
            state_d      = ST_EMIT_RD;
            cmd_o.rd_clr = 1'b1;
          end else begin
            state_d = ST_HEAD1;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.rd_inc   = 1'b1;
        state_d        = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = sts_i.out_last ? ST_HEAD1 : ST_EMIT_RD;
      end
      default: begin
        state_d = ST_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/sfr_dp.sv
`timescale 1ns / 1ps

module sfr_dp
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  sfr_cmd_t             cmd_i,
  output sfr_sts_t             sts_o,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic [LEN_OUT_W-1:0] frame_len_o,
  output logic                 empty_res_o,
  output logic                 last_o
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] head1_q, head2_q, tail1_q, tail2_q;
  logic [LW-1:0]     cnt_q, len_q;
  logic [BYTE_W-1:0] sum_q;
  logic [IW-1:0]     rd_q;
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

  logic [BYTE_W-1:0]    out_byte_q;
  logic [LEN_OUT_W-1:0] out_len_q;
  logic                 out_empty_q, out_last_q;

  logic [LW:0] cnt_inc;
  logic [LW:0] rd_inc;
  logic        len_q_zero;

  assign cnt_inc    = {1'b0, cnt_q} + 1'b1;
  assign rd_inc     = {1'b0, LW'(rd_q)} + 1'b1;
  assign len_q_zero = (len_q == '0);

  always_comb begin
    sts_o.head1_hit = (rx_byte_i == head1_q);
    sts_o.head2_hit = (rx_byte_i == head2_q);
    sts_o.tail1_hit = (rx_byte_i == tail1_q);
    sts_o.tail2_hit = (rx_byte_i == tail2_q);
    sts_o.sum_hit   = (rx_byte_i == sum_q);
    sts_o.len_big   = (rx_byte_i > BYTE_W'(MAX_PAYLOAD));
    sts_o.len_zero  = (rx_byte_i == '0);
    sts_o.data_done = (cnt_inc >= {1'b0, len_q});
    sts_o.out_last  = out_last_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head1_q <= HEAD_ONE_RST;
      head2_q <= HEAD_TWO_RST;
      tail1_q <= TAIL_ONE_RST;
      tail2_q <= TAIL_TWO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD_ONE: head1_q <= cfg_wdata_i;
        REG_HEAD_TWO: head2_q <= cfg_wdata_i;
        REG_TAIL_ONE: tail1_q <= cfg_wdata_i;
        REG_TAIL_TWO: tail2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frame counters and checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      sum_q <= '0;
      rd_q  <= '0;
    end else begin
      if (cmd_i.sum_clr) sum_q <= '0;
      if (cmd_i.len_load) begin
        len_q <= LW'(rx_byte_i);
        cnt_q <= '0;
      end
      if (cmd_i.data_wr) begin
        cnt_q <= cnt_inc[LW-1:0];
        sum_q <= sum_q + rx_byte_i;
      end
      if (cmd_i.rd_clr) rd_q <= '0;
      else if (cmd_i.rd_inc) rd_q <= rd_q + 1'b1;
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_wr) mem[cnt_q[IW-1:0]] <= rx_byte_i;
    if (cmd_i.rd_en) rdata_q <= mem[rd_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_empty_q <= len_q_zero;
      out_last_q  <= len_q_zero || (rd_inc == {1'b0, len_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= len_q_zero ? '0 : rdata_q;
      out_len_q  <= LEN_OUT_W'(len_q);
    end
  end

  assign payload_byte_o = out_byte_q;
  assign frame_len_o    = out_len_q;
  assign empty_res_o    = out_empty_q;
  assign last_o         = out_last_q;

endmodule

FILE: dv/frame_checker.sv
`timescale 1ns / 1ps

module frame_checker
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [BYTE_W-1:0]    payload_byte_i,
  input  logic [LEN_OUT_W-1:0] frame_len_i,
  input  logic                 empty_res_i,
  input  logic                 last_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef enum logic [2:0] {
    HUNT_HEAD1,
    HUNT_HEAD2,
    GET_LEN,
    GET_DATA,
    GET_SUM,
    GET_TAIL1,
    GET_TAIL2
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]    payload;
    logic [LEN_OUT_W-1:0] len;
    logic                 empty;
    logic                 last;
  } frame_item_t;

  logic [BYTE_W-1:0] head1, head2, tail1, tail2;
  parse_phase_e      phase;
  logic [7:0]        want_len;
  logic [5:0]        rx_pos;
  logic [7:0]        sum;
  logic [7:0]        payload_mem [MAX_PAYLOAD];
  frame_item_t       frame_items [$];
  frame_item_t       exp_item;
  frame_item_t       got_item;
  int                mismatches;

  // walk the frame parser by one received byte and queue any emitted items
  task automatic parse_byte(input logic [7:0] b);
    frame_item_t item;
    int          n;
    case (phase)
      HUNT_HEAD1: begin
        if (b == head1) phase = HUNT_HEAD2;
      end
      HUNT_HEAD2: begin
        if (b == head2) begin
          phase = GET_LEN;
          sum   = '0;
        end else begin
          phase = HUNT_HEAD1;
        end
      end
      GET_LEN: begin
        want_len = b;
        rx_pos   = '0;
        if (b > MAX_PAYLOAD) phase = HUNT_HEAD1;
        else if (b == 0) phase = GET_SUM;
        else phase = GET_DATA;
      end
      GET_DATA: begin
        if (rx_pos < MAX_PAYLOAD) payload_mem[rx_pos] = b;
        rx_pos = rx_pos + 6'd1;
        sum    = sum + b;
        if (rx_pos >= want_len) phase = GET_SUM;
      end
      GET_SUM: begin
        phase = (b == sum) ? GET_TAIL1 : HUNT_HEAD1;
      end
      GET_TAIL1: begin
        phase = (b == tail1) ? GET_TAIL2 : HUNT_HEAD1;
      end
      GET_TAIL2: begin
        if (b == tail2) begin
          if (want_len == 0) begin
            item = '{payload: '0, len: '0, empty: 1'b1, last: 1'b1};
            frame_items.push_back(item);
          end else begin
            n = (want_len > MAX_PAYLOAD) ? MAX_PAYLOAD : want_len;
            for (int i = 0; i < n; i++) begin
              item.payload = payload_mem[i];
              item.len     = want_len[LEN_OUT_W-1:0];
              item.empty   = 1'b0;
              item.last    = (i == n - 1);
              frame_items.push_back(item);
            end
          end
        end
        phase    = HUNT_HEAD1;
        want_len = '0;
        rx_pos   = '0;
        sum      = '0;
      end
      default: begin
        phase = HUNT_HEAD1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head1      = HEAD_ONE_RST;
      head2      = HEAD_TWO_RST;
      tail1      = TAIL_ONE_RST;
      tail2      = TAIL_TWO_RST;
      phase      = HUNT_HEAD1;
      want_len   = '0;
      rx_pos     = '0;
      sum        = '0;
      mismatches = 0;
      frame_items.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_item = '{payload: payload_byte_i, len: frame_len_i, empty: empty_res_i,
                     last: last_i};
        if (frame_items.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected: payload %0d len %0d empty %0d last %0d",
                     $realtime, got_item.payload, got_item.len, got_item.empty,
                     got_item.last);
          end
        end else begin
          exp_item = frame_items.pop_front();
          if (got_item.payload !== exp_item.payload || got_item.len !== exp_item.len ||
              got_item.empty !== exp_item.empty || got_item.last !== exp_item.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch payload %0d/%0d len %0d/%0d empty %0d/%0d last %0d/%0d",
                       $realtime, exp_item.payload, got_item.payload, exp_item.len,
                       got_item.len, exp_item.empty, got_item.empty, exp_item.last,
                       got_item.last);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEAD_ONE: head1 = cfg_wdata_i;
          REG_HEAD_TWO: head2 = cfg_wdata_i;
          REG_TAIL_ONE: tail1 = cfg_wdata_i;
          REG_TAIL_TWO: tail2 = cfg_wdata_i;
          default: ;
        endcase
      end
      errors_o  <= mismatches;
      pending_o <= frame_items.size();
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int MAX_PAYLOAD = 32;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    rx_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [BYTE_W-1:0]    payload_byte_o;
  logic [LEN_OUT_W-1:0] frame_len_o;
  logic                 empty_res_o;
  logic                 last_o;

  int                   fail_cnt;
  int                   items_due;
  int                   idle_pct;
  int                   stall_pct;
  int                   hold_req;
  int                   hold_ack;
  int                   bytes_sent;
  logic [BYTE_W-1:0]    head1, head2, tail1, tail2;

  serial_frame_receiver #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_o(payload_byte_o),
    .frame_len_o   (frame_len_o),
    .empty_res_o   (empty_res_o),
    .last_o        (last_o)
  );

  frame_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_i(payload_byte_o),
    .frame_len_i   (frame_len_o),
    .empty_res_i   (empty_res_o),
    .last_i        (last_o),
    .errors_o      (fail_cnt),
    .pending_o     (items_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_ack    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ack != hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_ack = hold_req;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (items_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] t1, input logic [7:0] t2);
    logic [REG_IDX_W-1:0] idx [4];
    logic [7:0]           val [4];
    idx = '{REG_HEAD_ONE, REG_HEAD_TWO, REG_TAIL_ONE, REG_TAIL_TWO};
    val = '{h1, h2, t1, t2};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    head1 = h1;
    head2 = h2;
    tail1 = t1;
    tail2 = t2;
  endtask

  // frame, optionally with one byte damaged; an oversized length sends only header and length
  task automatic send_frame(input int len, input bit damage);
    logic [7:0] bytes [$];
    logic [7:0] csum;
    logic [7:0] b;
    int         pos;
    csum = '0;
    bytes.push_back(head1);
    bytes.push_back(head2);
    bytes.push_back(len[7:0]);
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        b = $urandom_range(255);
        bytes.push_back(b);
        csum = csum + b;
      end
      bytes.push_back(csum);
      bytes.push_back(tail1);
      bytes.push_back(tail2);
    end
    if (damage) begin
      pos = $urandom_range(bytes.size() - 1);
      bytes[pos] = bytes[pos] ^ 8'($urandom_range(255, 1));
    end
    foreach (bytes[i]) push_byte(bytes[i]);
  endtask

  task automatic random_traffic(input int budget);
    int r;
    int len;
    int stop_at;
    stop_at = bytes_sent + budget;
    send_frame(MAX_PAYLOAD, 1'b0);
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end else if (r < 14) begin
        send_frame($urandom_range(255, MAX_PAYLOAD + 1), 1'b0);
      end else begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(6);
        else if (r < 95) len = $urandom_range(MAX_PAYLOAD - 1, 7);
        else len = MAX_PAYLOAD;
        send_frame(len, $urandom_range(99) < 20);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_HEAD_ONE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_req    = 0;
    bytes_sent  = 0;
    head1       = HEAD_ONE_RST;
    head2       = HEAD_TWO_RST;
    tail1       = TAIL_ONE_RST;
    tail2       = TAIL_TWO_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frame, one-byte frame at full scale, oversized length, repeated first header byte
    send_frame(0, 1'b0);
    push_byte(head1);
    push_byte(head2);
    push_byte(8'd1);
    push_byte(8'hff);
    push_byte(8'hff);
    push_byte(tail1);
    push_byte(tail2);
    send_frame(MAX_PAYLOAD + 1, 1'b0);
    push_byte(head1);
    push_byte(head1);
    push_byte(head2);
    drain();

    // no idling, with a long result hold-off at the start
    hold_req++;
    random_traffic(120);

    program_regs(8'h00, 8'h00, 8'h00, 8'h00);
    idle_pct  = 67;
    stall_pct = 0;
    random_traffic(120);

    program_regs(8'hff, 8'hff, 8'hff, 8'hff);
    idle_pct  = 0;
    stall_pct = 67;
    random_traffic(120);

    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    idle_pct  = 12;
    stall_pct = 12;
    random_traffic(120);

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: serial_frame_receiver.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_ctrl.sv
rtl/core/sfr_dp.sv
rtl/core/serial_frame_receiver.sv
dv/frame_checker.sv
dv/testbench.sv
